/* src/nrfe_pkg.sv */
// Shared constants, types and lookup functions for the RMC field extractor.
`default_nettype none

package nrfe_pkg;

    // Field capacities and sentence limit
    localparam int TIME_CHARS   = 10;
    localparam int LAT_CHARS    = 10;
    localparam int LON_CHARS    = 11;
    localparam int MAX_SENTENCE = 80;

    localparam int NUM_FIELDS  = 6;
    localparam int STORE_DEPTH = TIME_CHARS + 1 + LAT_CHARS + 1 + LON_CHARS + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = 4;
    localparam int SLEN_W      = 7;
    localparam int FID_W       = 3;
    localparam int CC_W        = 3;
    localparam int BYTE_W      = 8;

    // Length of "$GxRMC," counted into the sentence length
    localparam logic [SLEN_W-1:0] HEADER_LEN = SLEN_W'(7);
    localparam logic [CC_W-1:0]   CC_MAX     = 3'd7;

    // Characters
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

    // Field indexes within the store
    localparam logic [FID_W-1:0] IDX_TIME   = 3'd0;
    localparam logic [FID_W-1:0] IDX_STATUS = 3'd1;
    localparam logic [FID_W-1:0] IDX_LAT    = 3'd2;
    localparam logic [FID_W-1:0] IDX_NS     = 3'd3;
    localparam logic [FID_W-1:0] IDX_LON    = 3'd4;
    localparam logic [FID_W-1:0] IDX_EW     = 3'd5;
    localparam logic [FID_W-1:0] IDX_END    = 3'd6;

    // field_id of the closing record
    localparam logic [FID_W-1:0] FID_CLOSE  = 3'd0;

    typedef enum logic [2:0] {
        HDR_HUNT   = 3'd0,
        HDR_DOLLAR = 3'd1,
        HDR_G      = 3'd2,
        HDR_TALKER = 3'd3,
        HDR_R      = 3'd4,
        HDR_M      = 3'd5,
        HDR_C      = 3'd6
    } hdr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_LOAD,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic seek_next;
        logic rd;
        logic load_char;
        logic load_close;
    } nrfe_cmd_t;

    typedef struct packed {
        logic emit_hit;
        logic all_done;
        logic field_done;
        logic out_last;
    } nrfe_stat_t;

    function automatic logic [LEN_W-1:0] field_cap(input logic [FID_W-1:0] idx);
        logic [LEN_W-1:0] cap;
        case (idx)
            IDX_TIME:   cap = LEN_W'(TIME_CHARS);
            IDX_STATUS: cap = LEN_W'(1);
            IDX_LAT:    cap = LEN_W'(LAT_CHARS);
            IDX_NS:     cap = LEN_W'(1);
            IDX_LON:    cap = LEN_W'(LON_CHARS);
            IDX_EW:     cap = LEN_W'(1);
            default:    cap = '0;
        endcase
        return cap;
    endfunction

    function automatic logic [ADDR_W-1:0] field_base(input logic [FID_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        case (idx)
            IDX_TIME:   base = '0;
            IDX_STATUS: base = ADDR_W'(TIME_CHARS);
            IDX_LAT:    base = ADDR_W'(TIME_CHARS + 1);
            IDX_NS:     base = ADDR_W'(TIME_CHARS + 1 + LAT_CHARS);
            IDX_LON:    base = ADDR_W'(TIME_CHARS + 1 + LAT_CHARS + 1);
            IDX_EW:     base = ADDR_W'(TIME_CHARS + 1 + LAT_CHARS + 1 + LON_CHARS);
            default:    base = '0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

/* src/nmea_rmc_field_extractor_unit.sv */
// Top level of the NMEA RMC field extractor.
`default_nettype none

// Takes one received byte per transaction and picks out $GPRMC / $GNRMC sentences.
// Every byte that does not end a sentence is taken in a single cycle, so bytes may
// arrive back to back. On CR LF the stored characters of fields 1 to 6 are sent as
// one transaction each, in field order, followed by a closing record with last set;
// no byte is taken until the closing record has gone. The drain reads the character
// store through its single registered read port: each character passes through the
// seek, load and output states (address, read, present), each field ends with a seek
// step, and the closing record is loaded and then presented.

module nmea_rmc_field_extractor_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [nrfe_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [nrfe_pkg::FID_W-1:0]    m_field_id,
    output logic      [nrfe_pkg::LEN_W-1:0]    m_char_pos,
    output logic      [nrfe_pkg::BYTE_W-1:0]   m_char_value,
    output logic                               m_fix_valid,
    output logic                               m_talker_gn,
    output logic                               m_sentence_error,
    output logic                               m_overflow,
    output logic                               m_last
);

    nrfe_pkg::nrfe_cmd_t  cmd;
    nrfe_pkg::nrfe_stat_t stat;

    nrfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    nrfe_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rx_byte        (s_rx_byte),
        .cmd            (cmd),
        .stat           (stat),
        .field_id       (m_field_id),
        .char_pos       (m_char_pos),
        .char_value     (m_char_value),
        .fix_valid      (m_fix_valid),
        .talker_gn      (m_talker_gn),
        .sentence_error (m_sentence_error),
        .overflow       (m_overflow),
        .last           (m_last)
    );

endmodule

`default_nettype wire

/* src/nrfe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nrfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 34
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/nrfe_ctrl.sv */
// Controller state machine: byte intake and sequencing of the record drain.
`default_nettype none

module nrfe_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire nrfe_pkg::nrfe_stat_t stat,
    output nrfe_pkg::nrfe_cmd_t     cmd
);

    nrfe_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nrfe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            nrfe_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (stat.emit_hit) begin
                        state_next = nrfe_pkg::ST_SEEK;
                    end
                end
            end
            nrfe_pkg::ST_SEEK: begin
                if (stat.all_done) begin
                    cmd.load_close = 1'b1;
                    state_next     = nrfe_pkg::ST_OUT;
                end else if (stat.field_done) begin
                    cmd.seek_next = 1'b1;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = nrfe_pkg::ST_LOAD;
                end
            end
            nrfe_pkg::ST_LOAD: begin
                cmd.load_char = 1'b1;
                state_next    = nrfe_pkg::ST_OUT;
            end
            nrfe_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = stat.out_last ? nrfe_pkg::ST_IDLE : nrfe_pkg::ST_SEEK;
                end
            end
            default: begin
                state_next = nrfe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/nrfe_dp.sv */
// Datapath: header match, field capture into the character store, drain cursor and output register.
`default_nettype none

module nrfe_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [nrfe_pkg::BYTE_W-1:0]    rx_byte,
    input  wire nrfe_pkg::nrfe_cmd_t            cmd,
    output nrfe_pkg::nrfe_stat_t                stat,
    output logic      [nrfe_pkg::FID_W-1:0]     field_id,
    output logic      [nrfe_pkg::LEN_W-1:0]     char_pos,
    output logic      [nrfe_pkg::BYTE_W-1:0]    char_value,
    output logic                                fix_valid,
    output logic                                talker_gn,
    output logic                                sentence_error,
    output logic                                overflow,
    output logic                                last
);

    localparam int NF = nrfe_pkg::NUM_FIELDS;

    // Sentence state
    nrfe_pkg::hdr_t                  hdr_reg, hdr_next;
    logic                            gn_reg, gn_next;
    logic                            insent_reg, insent_next;
    logic [nrfe_pkg::CC_W-1:0]       cc_reg, cc_next;
    logic                            cr_reg, cr_next;
    logic [nrfe_pkg::SLEN_W-1:0]     slen_reg, slen_next;
    logic                            ovf_reg, ovf_next;
    logic                            sta_reg, sta_next;
    logic [nrfe_pkg::LEN_W-1:0]      flen_reg [NF];
    logic [nrfe_pkg::LEN_W-1:0]      flen_next [NF];

    // Drain cursor
    logic [nrfe_pkg::FID_W-1:0]      fcur_reg, fcur_next;
    logic [nrfe_pkg::LEN_W-1:0]      pcur_reg, pcur_next;

    // Output record
    logic [nrfe_pkg::FID_W-1:0]      fid_reg;
    logic [nrfe_pkg::LEN_W-1:0]      pos_reg;
    logic [nrfe_pkg::BYTE_W-1:0]     val_reg;
    logic                            fix_reg, tgn_reg, serr_reg, oflag_reg;
    logic                            last_reg, last_next;

    logic [nrfe_pkg::FID_W-1:0]      idx;
    logic [nrfe_pkg::LEN_W-1:0]      flen_cur;
    logic                            data_field;
    logic                            wr_en;
    logic [nrfe_pkg::ADDR_W-1:0]     wr_addr;
    logic [nrfe_pkg::ADDR_W-1:0]     rd_addr;
    logic [nrfe_pkg::BYTE_W-1:0]     rd_data;

    // One length lookup, shared: capture field while in a sentence, drain cursor otherwise
    assign idx        = insent_reg ? (cc_reg - nrfe_pkg::CC_W'(1)) : fcur_reg;
    assign flen_cur   = (idx < nrfe_pkg::FID_W'(NF)) ? flen_reg[idx] : '0;
    assign data_field = (cc_reg != '0) && (cc_reg <= nrfe_pkg::CC_W'(NF));
    assign wr_addr    = nrfe_pkg::field_base(idx) + nrfe_pkg::ADDR_W'(flen_cur);
    assign rd_addr    = nrfe_pkg::field_base(fcur_reg) + nrfe_pkg::ADDR_W'(pcur_reg);

    assign stat.emit_hit   = insent_reg && cr_reg && (rx_byte == nrfe_pkg::CH_LF);
    assign stat.all_done   = (fcur_reg == nrfe_pkg::IDX_END);
    assign stat.field_done = (pcur_reg >= flen_cur);
    assign stat.out_last   = last_reg;

    always_comb begin
        hdr_next    = hdr_reg;
        gn_next     = gn_reg;
        insent_next = insent_reg;
        cc_next     = cc_reg;
        cr_next     = cr_reg;
        slen_next   = slen_reg;
        ovf_next    = ovf_reg;
        sta_next    = sta_reg;
        flen_next   = flen_reg;
        fcur_next   = fcur_reg;
        pcur_next   = pcur_reg;
        wr_en       = 1'b0;

        if (cmd.take) begin
            if (insent_reg && cr_reg) begin
                cr_next = 1'b0;
            end
            if (stat.emit_hit) begin
                insent_next = 1'b0;
                hdr_next    = nrfe_pkg::HDR_HUNT;
                cr_next     = 1'b0;
                fcur_next   = nrfe_pkg::IDX_TIME;
                pcur_next   = '0;
            end else if (rx_byte == nrfe_pkg::CH_DOLLAR) begin
                hdr_next    = nrfe_pkg::HDR_DOLLAR;
                insent_next = 1'b0;
                cr_next     = 1'b0;
            end else if (insent_reg) begin
                if (rx_byte == nrfe_pkg::CH_CR) begin
                    cr_next = 1'b1;
                end else if (slen_reg >= nrfe_pkg::SLEN_W'(nrfe_pkg::MAX_SENTENCE)) begin
                    ovf_next = 1'b1;
                end else begin
                    slen_next = slen_reg + nrfe_pkg::SLEN_W'(1);
                    if (rx_byte == nrfe_pkg::CH_COMMA) begin
                        if (cc_reg != nrfe_pkg::CC_MAX) begin
                            cc_next = cc_reg + nrfe_pkg::CC_W'(1);
                        end
                    end else if (data_field) begin
                        if (flen_cur < nrfe_pkg::field_cap(idx)) begin
                            wr_en          = 1'b1;
                            flen_next[idx] = flen_cur + nrfe_pkg::LEN_W'(1);
                            // first status character decides the fix flag
                            if (idx == nrfe_pkg::IDX_STATUS && flen_cur == '0) begin
                                sta_next = (rx_byte == nrfe_pkg::CH_A);
                            end
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end else begin
                case (hdr_reg)
                    nrfe_pkg::HDR_DOLLAR: begin
                        hdr_next = (rx_byte == nrfe_pkg::CH_G) ? nrfe_pkg::HDR_G
                                                               : nrfe_pkg::HDR_HUNT;
                    end
                    nrfe_pkg::HDR_G: begin
                        if (rx_byte == nrfe_pkg::CH_P || rx_byte == nrfe_pkg::CH_N) begin
                            gn_next  = (rx_byte == nrfe_pkg::CH_N);
                            hdr_next = nrfe_pkg::HDR_TALKER;
                        end else begin
                            hdr_next = nrfe_pkg::HDR_HUNT;
                        end
                    end
                    nrfe_pkg::HDR_TALKER: begin
                        hdr_next = (rx_byte == nrfe_pkg::CH_R) ? nrfe_pkg::HDR_R
                                                               : nrfe_pkg::HDR_HUNT;
                    end
                    nrfe_pkg::HDR_R: begin
                        hdr_next = (rx_byte == nrfe_pkg::CH_M) ? nrfe_pkg::HDR_M
                                                               : nrfe_pkg::HDR_HUNT;
                    end
                    nrfe_pkg::HDR_M: begin
                        hdr_next = (rx_byte == nrfe_pkg::CH_C) ? nrfe_pkg::HDR_C
                                                               : nrfe_pkg::HDR_HUNT;
                    end
                    nrfe_pkg::HDR_C: begin
                        hdr_next = nrfe_pkg::HDR_HUNT;
                        if (rx_byte == nrfe_pkg::CH_COMMA) begin
                            insent_next = 1'b1;
                            cc_next     = nrfe_pkg::CC_W'(1);
                            cr_next     = 1'b0;
                            slen_next   = nrfe_pkg::HEADER_LEN;
                            ovf_next    = 1'b0;
                            for (int i = 0; i < NF; i++) begin
                                flen_next[i] = '0;
                            end
                        end
                    end
                    default: begin
                        hdr_next = nrfe_pkg::HDR_HUNT;
                    end
                endcase
            end
        end

        if (cmd.seek_next) begin
            fcur_next = fcur_reg + nrfe_pkg::FID_W'(1);
            pcur_next = '0;
        end
        if (cmd.load_char) begin
            pcur_next = pcur_reg + nrfe_pkg::LEN_W'(1);
        end
    end

    always_comb begin
        last_next = last_reg;
        if (cmd.load_char) begin
            last_next = 1'b0;
        end else if (cmd.load_close) begin
            last_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg    <= nrfe_pkg::HDR_HUNT;
            gn_reg     <= 1'b0;
            insent_reg <= 1'b0;
            cc_reg     <= '0;
            cr_reg     <= 1'b0;
            slen_reg   <= '0;
            ovf_reg    <= 1'b0;
            for (int i = 0; i < NF; i++) begin
                flen_reg[i] <= '0;
            end
            fcur_reg   <= '0;
            pcur_reg   <= '0;
            last_reg   <= 1'b0;
        end else begin
            hdr_reg    <= hdr_next;
            gn_reg     <= gn_next;
            insent_reg <= insent_next;
            cc_reg     <= cc_next;
            cr_reg     <= cr_next;
            slen_reg   <= slen_next;
            ovf_reg    <= ovf_next;
            flen_reg   <= flen_next;
            fcur_reg   <= fcur_next;
            pcur_reg   <= pcur_next;
            last_reg   <= last_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        sta_reg <= sta_next;
        if (cmd.load_char) begin
            fid_reg   <= fcur_reg + nrfe_pkg::FID_W'(1);
            pos_reg   <= pcur_reg;
            val_reg   <= rd_data;
            fix_reg   <= 1'b0;
            tgn_reg   <= 1'b0;
            serr_reg  <= 1'b0;
            oflag_reg <= 1'b0;
        end else if (cmd.load_close) begin
            fid_reg   <= nrfe_pkg::FID_CLOSE;
            pos_reg   <= '0;
            val_reg   <= '0;
            fix_reg   <= (flen_reg[nrfe_pkg::IDX_STATUS] != '0) && sta_reg;
            tgn_reg   <= gn_reg;
            serr_reg  <= (cc_reg != nrfe_pkg::CC_MAX);
            oflag_reg <= ovf_reg;
        end
    end

    nrfe_ram #(
        .WIDTH (nrfe_pkg::BYTE_W),
        .DEPTH (nrfe_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign field_id       = fid_reg;
    assign char_pos       = pos_reg;
    assign char_value     = val_reg;
    assign fix_valid      = fix_reg;
    assign talker_gn      = tgn_reg;
    assign sentence_error = serr_reg;
    assign overflow       = oflag_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

/* src/nrfe_checker.sv */
// Port-level checker for the RMC field extractor, bound to the top level.
`default_nettype none

module nrfe_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic [nrfe_pkg::BYTE_W-1:0] s_rx_byte,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [nrfe_pkg::FID_W-1:0]  m_field_id,
    input wire logic [nrfe_pkg::LEN_W-1:0]  m_char_pos,
    input wire logic [nrfe_pkg::BYTE_W-1:0] m_char_value,
    input wire logic                        m_fix_valid,
    input wire logic                        m_talker_gn,
    input wire logic                        m_sentence_error,
    input wire logic                        m_overflow,
    input wire logic                        m_last
);

    // No byte is taken while a record is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while output record pending");

    // A byte other than LF never starts a drain
    a_no_spurious_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_rx_byte != nrfe_pkg::CH_LF) |=> s_ready)
        else $error("drain started without LF");

    // Closing record ends the run and frees the input
    a_close_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (!m_valid && s_ready))
        else $error("run did not end after closing record");

    // Record kinds are consistent
    a_record_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last ? (m_field_id == nrfe_pkg::FID_CLOSE && m_char_value == '0
                               && m_char_pos == '0)
                            : (m_field_id != nrfe_pkg::FID_CLOSE && !m_fix_valid
                               && !m_talker_gn && !m_sentence_error && !m_overflow)))
        else $error("malformed output record");

    // Pending record holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_char_value)
                                   && $stable(m_field_id) && $stable(m_last)))
        else $error("output record changed while stalled");

endmodule

bind nmea_rmc_field_extractor_unit nrfe_checker u_nrfe_checker (.*);

`default_nettype wire

/* tb/nrfe_rmc_checker.sv */
`timescale 1ns / 1ps
// Channel monitor for the RMC field extractor: tracks sentences and checks every output record.
module nrfe_rmc_checker
    import nrfe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [BYTE_W-1:0] s_rx_byte,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [FID_W-1:0]  m_field_id,
    input  wire logic [LEN_W-1:0]  m_char_pos,
    input  wire logic [BYTE_W-1:0] m_char_value,
    input  wire logic              m_fix_valid,
    input  wire logic              m_talker_gn,
    input  wire logic              m_sentence_error,
    input  wire logic              m_overflow,
    input  wire logic              m_last,
    output int                     mismatches,
    output int                     backlog
);

    typedef struct packed {
        logic [FID_W-1:0]  field_id;
        logic [LEN_W-1:0]  char_pos;
        logic [BYTE_W-1:0] char_value;
        logic              fix_valid;
        logic              talker_gn;
        logic              sentence_error;
        logic              overflow;
        logic              last;
    } rmc_rec_t;

    rmc_rec_t    rmc_records_due [$];
    int          fail_tally;

    // Sentence tracking state
    hdr_t        hdr_pos;
    logic        gn_talker;
    logic        in_sent;
    logic        cr_seen;
    logic        sent_ovf;
    int unsigned commas;
    int unsigned sent_len;
    int unsigned fld_len   [NUM_FIELDS];
    logic [7:0]  fld_chars [NUM_FIELDS][16];

    function automatic int unsigned field_room(input int f);
        case (f)
            IDX_TIME: return TIME_CHARS;
            IDX_LAT:  return LAT_CHARS;
            IDX_LON:  return LON_CHARS;
            default:  return 1;
        endcase
    endfunction

    task automatic queue_sentence_records();
        rmc_rec_t r;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            for (int p = 0; p < fld_len[f]; p++) begin
                r = '0;
                r.field_id   = FID_W'(f + 1);
                r.char_pos   = LEN_W'(p);
                r.char_value = fld_chars[f][p];
                rmc_records_due.push_back(r);
            end
        end
        r = '0;
        r.field_id       = FID_CLOSE;
        r.fix_valid      = (fld_len[IDX_STATUS] >= 1) && (fld_chars[IDX_STATUS][0] == CH_A);
        r.talker_gn      = gn_talker;
        r.sentence_error = (commas < CC_MAX);
        r.overflow       = sent_ovf;
        r.last           = 1'b1;
        rmc_records_due.push_back(r);
        in_sent = 1'b0;
        cr_seen = 1'b0;
        hdr_pos = HDR_HUNT;
    endtask

    task automatic track_rx_byte(input logic [7:0] c);
        int   f;
        logic lf_ends;
        lf_ends = in_sent && cr_seen && (c == CH_LF);
        if (in_sent)
            cr_seen = 1'b0;
        if (lf_ends) begin
            queue_sentence_records();
        end else if (c == CH_DOLLAR) begin
            // drops any sentence in progress
            hdr_pos = HDR_DOLLAR;
            in_sent = 1'b0;
            cr_seen = 1'b0;
        end else if (in_sent) begin
            if (c == CH_CR) begin
                cr_seen = 1'b1;
            end else if (sent_len >= MAX_SENTENCE) begin
                sent_ovf = 1'b1;
            end else begin
                sent_len++;
                if (c == CH_COMMA) begin
                    if (commas < CC_MAX)
                        commas++;
                end else if (commas >= 1 && commas <= NUM_FIELDS) begin
                    f = commas - 1;
                    if (fld_len[f] < field_room(f)) begin
                        fld_chars[f][fld_len[f]] = c;
                        fld_len[f]++;
                    end else begin
                        sent_ovf = 1'b1;
                    end
                end
            end
        end else begin
            case (hdr_pos)
                HDR_DOLLAR: hdr_pos = (c == CH_G) ? HDR_G : HDR_HUNT;
                HDR_G: begin
                    if (c == CH_P || c == CH_N) begin
                        gn_talker = (c == CH_N);
                        hdr_pos   = HDR_TALKER;
                    end else begin
                        hdr_pos = HDR_HUNT;
                    end
                end
                HDR_TALKER: hdr_pos = (c == CH_R) ? HDR_R : HDR_HUNT;
                HDR_R:      hdr_pos = (c == CH_M) ? HDR_M : HDR_HUNT;
                HDR_M:      hdr_pos = (c == CH_C) ? HDR_C : HDR_HUNT;
                HDR_C: begin
                    hdr_pos = HDR_HUNT;
                    if (c == CH_COMMA) begin
                        in_sent  = 1'b1;
                        commas   = 1;
                        sent_len = HEADER_LEN;
                        sent_ovf = 1'b0;
                        cr_seen  = 1'b0;
                        for (int i = 0; i < NUM_FIELDS; i++)
                            fld_len[i] = 0;
                    end
                end
                default: hdr_pos = HDR_HUNT;
            endcase
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge aclk) begin
        rmc_rec_t exp_rec;
        if (!aresetn) begin
            rmc_records_due.delete();
            fail_tally = 0;
            hdr_pos    = HDR_HUNT;
            gn_talker  = 1'b0;
            in_sent    = 1'b0;
            cr_seen    = 1'b0;
            sent_ovf   = 1'b0;
            commas     = 0;
            sent_len   = 0;
            for (int i = 0; i < NUM_FIELDS; i++)
                fld_len[i] = 0;
        end else begin
            // output side first: a byte taken this edge cannot have produced a record yet
            if (m_valid && m_ready) begin
                if (rmc_records_due.size() == 0) begin
                    $error("record with nothing outstanding: field_id %0d char_pos %0d last %0b",
                           m_field_id, m_char_pos, m_last);
                    fail_tally++;
                end else begin
                    exp_rec = rmc_records_due.pop_front();
                    compare_field("field_id", exp_rec.field_id, m_field_id);
                    compare_field("char_pos", exp_rec.char_pos, m_char_pos);
                    compare_field("char_value", exp_rec.char_value, m_char_value);
                    compare_field("fix_valid", exp_rec.fix_valid, m_fix_valid);
                    compare_field("talker_gn", exp_rec.talker_gn, m_talker_gn);
                    compare_field("sentence_error", exp_rec.sentence_error, m_sentence_error);
                    compare_field("overflow", exp_rec.overflow, m_overflow);
                    compare_field("last", exp_rec.last, m_last);
                end
            end
            if (s_valid && s_ready)
                track_rx_byte(s_rx_byte);
        end
        mismatches <= fail_tally;
        backlog    <= rmc_records_due.size();
    end

endmodule

/* tb/nmea_rmc_field_extractor_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top: feeds RMC byte streams to the field extractor and gives the verdict.
module nmea_rmc_field_extractor_unit_tb;
    import nrfe_pkg::*;

    localparam int BYTE_BUDGET  = 150;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [BYTE_W-1:0] CH_V = 8'h56;

    typedef enum int {
        K_CLEAN,
        K_LONG_FIELD,
        K_LONG_SENTENCE,
        K_RESTART,
        K_BAD_HEADER,
        K_LINE_BREAKS,
        K_SHORT,
        K_COUNT
    } sentence_kind_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte;
    logic              m_valid;
    logic              m_ready;
    logic [FID_W-1:0]  m_field_id;
    logic [LEN_W-1:0]  m_char_pos;
    logic [BYTE_W-1:0] m_char_value;
    logic              m_fix_valid;
    logic              m_talker_gn;
    logic              m_sentence_error;
    logic              m_overflow;
    logic              m_last;
    int                mismatches;
    int                backlog;

    logic [7:0]        tx_bytes [$];
    bit                gappy;
    bit                calm;

    nmea_rmc_field_extractor_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_field_id       (m_field_id),
        .m_char_pos       (m_char_pos),
        .m_char_value     (m_char_value),
        .m_fix_valid      (m_fix_valid),
        .m_talker_gn      (m_talker_gn),
        .m_sentence_error (m_sentence_error),
        .m_overflow       (m_overflow),
        .m_last           (m_last)
    );

    nrfe_rmc_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_field_id       (m_field_id),
        .m_char_pos       (m_char_pos),
        .m_char_value     (m_char_value),
        .m_fix_valid      (m_fix_valid),
        .m_talker_gn      (m_talker_gn),
        .m_sentence_error (m_sentence_error),
        .m_overflow       (m_overflow),
        .m_last           (m_last),
        .mismatches       (mismatches),
        .backlog          (backlog)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Field content: never a delimiter, so sentence structure stays as built
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_DOLLAR || c == CH_COMMA || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] status_char();
        case ($urandom_range(0, 2))
            0:       return CH_A;
            1:       return CH_V;
            default: return plain_char();
        endcase
    endfunction

    task automatic put_text(input string s, input int n);
        for (int i = 0; i < n; i++)
            tx_bytes.push_back(s[i]);
    endtask

    task automatic add_sentence(input int kind);
        int    room [NUM_FIELDS];
        int    lens [NUM_FIELDS];
        int    cut;
        int    n;
        int    base;
        int    f;
        string hdr;
        room = '{TIME_CHARS, 1, LAT_CHARS, 1, LON_CHARS, 1};
        if (kind == K_RESTART) begin
            // part of a header, or a whole one with some data, then a fresh '$'
            hdr = $urandom_range(0, 1) ? "$GNRMC," : "$GPRMC,";
            n = $urandom_range(1, 7);
            put_text(hdr, n);
            if (n == 7)
                repeat ($urandom_range(0, 6)) tx_bytes.push_back(plain_char());
        end
        hdr = $urandom_range(0, 1) ? "$GNRMC," : "$GPRMC,";
        for (f = 0; f < NUM_FIELDS; f++)
            lens[f] = $urandom_range(0, (room[f] + 1) / 2);
        if (kind == K_LONG_FIELD) begin
            f = $urandom_range(0, NUM_FIELDS - 1);
            lens[f] = room[f] + $urandom_range(1, 4);
        end
        if (kind == K_LONG_SENTENCE)
            lens = room;
        cut = (kind == K_SHORT) ? $urandom_range(0, NUM_FIELDS - 1) : NUM_FIELDS;
        base = tx_bytes.size();
        put_text(hdr, 7);
        if (kind == K_BAD_HEADER)
            tx_bytes[base + $urandom_range(1, 6)] = 8'($urandom_range(0, 255));
        // CR followed by data rather than LF
        if (kind == K_LINE_BREAKS)
            tx_bytes.push_back(CH_CR);
        for (f = 0; f < cut; f++) begin
            if (f > 0)
                tx_bytes.push_back(CH_COMMA);
            for (int p = 0; p < lens[f]; p++) begin
                if (f == IDX_STATUS && p == 0)
                    tx_bytes.push_back(status_char());
                else if (kind == K_LINE_BREAKS && f == IDX_LAT && p == 0)
                    tx_bytes.push_back(CH_LF);
                else
                    tx_bytes.push_back(plain_char());
            end
        end
        if (cut == NUM_FIELDS) begin
            // trailing RMC fields, often with further commas
            tx_bytes.push_back(CH_COMMA);
            n = (kind == K_LONG_SENTENCE) ? $urandom_range(34, 40) : $urandom_range(0, 3);
            repeat (n) tx_bytes.push_back($urandom_range(0, 3) == 0 ? CH_COMMA : plain_char());
        end
        if (kind == K_LINE_BREAKS)
            tx_bytes.push_back(CH_CR);
        tx_bytes.push_back(CH_CR);
        tx_bytes.push_back(CH_LF);
        // line noise between sentences
        repeat ($urandom_range(0, 2)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Leaves s_valid high after the final transaction; callers lower it or carry on
    task automatic send_queued();
        while (tx_bytes.size() > 0) begin
            s_valid   <= 1'b1;
            s_rx_byte <= tx_bytes.pop_front();
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (gappy && tx_bytes.size() > 0 && $urandom_range(0, 4) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
    endtask

    initial begin
        forever begin
            if (calm || $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    end

    initial begin
        int kind;
        int sent_total;
        int sentence_no;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        gappy = 1'b0;
        calm  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // GN fix with extreme data bytes and seven commas, then a bare GP header
        put_text("$GNRMC,", 7);
        tx_bytes.push_back(8'hFF);
        put_text(",A,", 3);
        tx_bytes.push_back(8'h00);
        put_text(",,,E,\r\n", 7);
        put_text("$GPRMC,\r\n", 9);
        send_queued();
        hold_until_drained();

        sent_total  = 0;
        sentence_no = 0;
        while (sent_total < BYTE_BUDGET || sentence_no < K_COUNT) begin
            if (sentence_no < K_COUNT)
                kind = sentence_no;
            else
                kind = $urandom_range(0, 1) ? K_CLEAN : $urandom_range(1, K_COUNT - 1);
            calm  = (sentence_no >= K_COUNT) && (sent_total >= BYTE_BUDGET - 40);
            gappy = !calm && $urandom_range(0, 2) != 0;
            add_sentence(kind);
            sent_total += tx_bytes.size();
            send_queued();
            sentence_no++;
            if (!calm && $urandom_range(0, 3) == 0)
                hold_until_drained();
        end

        // closing stretch with no idling on either side
        calm  = 1'b1;
        gappy = 1'b0;
        add_sentence(K_CLEAN);
        send_queued();

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && backlog == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
src/nrfe_pkg.sv
src/nrfe_ram.sv
src/nrfe_ctrl.sv
src/nrfe_dp.sv
src/nmea_rmc_field_extractor_unit.sv
src/nrfe_checker.sv
tb/nrfe_rmc_checker.sv
tb/nmea_rmc_field_extractor_unit_tb.sv
